>>> src/assert_macros.svh
// assertion macros shared by the texture sampler rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold whenever reset is released
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// signal must never be unknown out of reset
`define ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_KNOWN(label, clk, rst_n, sig, msg)
`endif
`endif

>>> src/texs_pkg.sv
// types and constants of the texture sampler
// no dependencies
package texs_pkg;
  localparam int unsigned CompW  = 16;
  localparam int unsigned ColorW = 3 * CompW;
  localparam int unsigned DimW   = 13;
  localparam int unsigned CoordW = 16;
  localparam int unsigned SumW   = 18;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_COLOR = 2'd1,
    REQ_INTEN = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_SOLID = 2'd0,
    MODE_IMAGE = 2'd1,
    MODE_CHECK = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  localparam logic [CfgIdxW-1:0] CFG_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GRAY   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SOLID  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ODD    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_EVEN   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SCALE  = 3'd7;

  // configuration seen by the datapath
  typedef struct packed {
    mode_e                 mode;
    logic [DimW-1:0]       width;
    logic [DimW-1:0]       height;
    logic                  gray;
    logic [ColorW-1:0]     solid;
    logic [ColorW-1:0]     odd;
    logic [ColorW-1:0]     even;
    logic [9:0]            scale;
  } cfg_t;

  // per-request control carried down the pipe
  typedef struct packed {
    logic  valid;
    req_e  req;
  } ctl_t;

  // one-dimensional lerp with round half up
  function automatic logic [CompW-1:0] lerp(input logic [CompW-1:0] c0,
                                            input logic [CompW-1:0] c1,
                                            input logic [15:0] f);
    logic [33:0] acc;
    begin
      acc = {18'd0, c0} * ({1'b0, 17'h10000} - {1'b0, f}) + {18'd0, c1} * {18'd0, f}
            + 34'd32768;
      lerp = acc[16 +: CompW];
    end
  endfunction
endpackage

>>> src/texs_addr.sv
// address stage: texel coordinates, wrap neighbours, weights, checker color
// depends on texs_pkg
module texs_addr (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  texs_pkg::cfg_t           cfg_i,
  input  logic [15:0]              u_i,
  input  logic [15:0]              v_i,
  output logic [12:0]              x0_o,
  output logic [12:0]              x1_o,
  output logic [12:0]              y0_o,
  output logic [12:0]              y1_o,
  output logic [15:0]              fa_o,
  output logic [15:0]              fb_o,
  output logic [texs_pkg::ColorW-1:0] chk_o
);
  import texs_pkg::*;
  logic [DimW-1:0] w, h;
  logic [28:0] px, py;
  logic [12:0] xi, yi;
  logic [13:0] xn, yn;
  logic [26:0] sx, sy;
  logic [10:0] s2;

  // scale coordinates by image size, zero size acts as one
  always_comb begin
    w  = (cfg_i.width  == '0) ? DimW'(1) : cfg_i.width;
    h  = (cfg_i.height == '0) ? DimW'(1) : cfg_i.height;
    px = u_i * w;
    py = v_i * h;
    xi = px[28:16];
    yi = py[28:16];
    xn = {1'b0, xi} + 14'd1;
    yn = {1'b0, yi} + 14'd1;
    s2 = {cfg_i.scale, 1'b0};
    sx = u_i * s2;
    sy = v_i * s2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_o  <= xi;
      y0_o  <= yi;
      x1_o  <= (xn == {1'b0, w}) ? 13'd0 : xn[12:0];
      y1_o  <= (yn == {1'b0, h}) ? 13'd0 : yn[12:0];
      fa_o  <= px[15:0];
      fb_o  <= py[15:0];
      chk_o <= (sx[16] ^ sy[16]) ? cfg_i.odd : cfg_i.even;
    end
  end
endmodule

>>> src/texs_mem.sv
// texel memory with four read banks for the bilinear corners
// depends on texs_pkg
module texs_mem #(
  parameter int unsigned Depth = 65536
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        we_i,
  input  logic [15:0]                 waddr_i,
  input  logic [texs_pkg::ColorW-1:0] wdata_i,
  input  logic [25:0]                 raddr_i [4],
  output logic [texs_pkg::ColorW-1:0] rdata_o [4],
  output logic [3:0]                  rok_o
);
  import texs_pkg::*;
  localparam int unsigned AW = $clog2(Depth);
  // four copies written together so every corner has its own read port
  logic [ColorW-1:0] mem0 [Depth];
  logic [ColorW-1:0] mem1 [Depth];
  logic [ColorW-1:0] mem2 [Depth];
  logic [ColorW-1:0] mem3 [Depth];
  logic wok;
  logic [3:0] rin;
  logic [AW-1:0] wa;

  assign wok = ({10'd0, waddr_i} < 26'(Depth));
  assign wa  = AW'({10'd0, waddr_i});
  always_comb begin
    for (int k = 0; k < 4; k++) rin[k] = raddr_i[k] < 26'(Depth);
  end

  always_ff @(posedge clk_i) begin
    if (we_i && wok) begin
      mem0[wa] <= wdata_i;
      mem1[wa] <= wdata_i;
      mem2[wa] <= wdata_i;
      mem3[wa] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_o[0] <= mem0[raddr_i[0][AW-1:0]];
      rdata_o[1] <= mem1[raddr_i[1][AW-1:0]];
      rdata_o[2] <= mem2[raddr_i[2][AW-1:0]];
      rdata_o[3] <= mem3[raddr_i[3][AW-1:0]];
      rok_o      <= rin;
    end
  end
endmodule

>>> src/texs_blend.sv
// blend stages: horizontal lerps, then vertical lerp
// depends on texs_pkg
module texs_blend (
  input  logic                        clk_i,
  input  logic                        en1_i,
  input  logic                        en2_i,
  input  logic [texs_pkg::ColorW-1:0] c_i [4],
  input  logic [15:0]                 fa_i,
  input  logic [15:0]                 fb_i,
  output logic [texs_pkg::ColorW-1:0] c_o
);
  import texs_pkg::*;
  logic [ColorW-1:0] up_q, dn_q;
  logic [15:0] fb_q;

  // horizontal pass on upper and lower rows
  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      for (int k = 0; k < 3; k++) begin
        up_q[k*CompW +: CompW] <= lerp(c_i[0][k*CompW +: CompW], c_i[1][k*CompW +: CompW], fa_i);
        dn_q[k*CompW +: CompW] <= lerp(c_i[2][k*CompW +: CompW], c_i[3][k*CompW +: CompW], fa_i);
      end
      fb_q <= fb_i;
    end
  end

  // vertical pass
  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      for (int k = 0; k < 3; k++)
        c_o[k*CompW +: CompW] <= lerp(up_q[k*CompW +: CompW], dn_q[k*CompW +: CompW], fb_q);
    end
  end
endmodule

>>> src/texture_sampler.sv
// texture sampler top level: config registers, pipeline control, output
// depends on texs_pkg, texs_addr, texs_mem, texs_blend, assert_macros.svh
// Texture sampler. One request is taken per cycle with no bubbles while the
// output is not stalled; each sample passes through coordinate scale, corner
// address with memory read, horizontal blend, and vertical blend with output
// register. The texel memory is kept as four identical banks written
// together, so all four bilinear corners are read in the same cycle.
// A stall on the output freezes the whole pipe. Texel writes return nothing;
// an unwritten texel reads as undefined.
module texture_sampler #(
  parameter int unsigned MAX_TEXELS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] u_coord_i,
  input  logic [15:0] v_coord_i,
  input  logic [15:0] texel_addr_i,
  input  logic [15:0] texel_red_i,
  input  logic [15:0] texel_green_i,
  input  logic [15:0] texel_blue_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] color_red_o,
  output logic [15:0] color_green_o,
  output logic [15:0] color_blue_o,
  output logic [17:0] intensity_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  import texs_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned NStg = 4;
  localparam logic [CompW-1:0] One = CompW'(1) << (CompW - 4);

  cfg_t cfg_q;
  ctl_t ctl_q [NStg];
  logic adv;
  logic [15:0] u1_q, v1_q;
  logic [12:0] x0, x1, y0, y1;
  logic [15:0] fa, fb, fa_q, fb_q;
  logic [ColorW-1:0] chk;
  logic [ColorW-1:0] fix_q [3];
  logic [25:0] ra [4];
  logic [25:0] row0, row1;
  logic [ColorW-1:0] rd [4], rdg [4];
  logic [3:0] rok;
  logic [ColorW-1:0] bl;
  logic [17:0] sum_q [2];
  logic [ColorW-1:0] res;
  logic [17:0] isum;
  req_e in_req;

  assign adv       = !(ctl_q[NStg-1].valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign in_req    = req_e'(req_type_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_SOLID, width: DimW'(1), height: DimW'(1), gray: 1'b0,
                 solid: '0, odd: '0, even: '0, scale: 10'd1};
    end else if (cfg_valid) begin
      case (cfg_index_i)
        CFG_MODE:   cfg_q.mode   <= mode_e'(cfg_data_i[1:0]);
        CFG_WIDTH:  cfg_q.width  <= cfg_data_i[DimW-1:0];
        CFG_HEIGHT: cfg_q.height <= cfg_data_i[DimW-1:0];
        CFG_GRAY:   cfg_q.gray   <= cfg_data_i[0];
        CFG_SOLID:  cfg_q.solid  <= cfg_data_i;
        CFG_ODD:    cfg_q.odd    <= cfg_data_i;
        CFG_EVEN:   cfg_q.even   <= cfg_data_i;
        CFG_SCALE:  cfg_q.scale  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // control valid bits, sample requests only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NStg; s++) ctl_q[s] <= '{valid: 1'b0, req: REQ_NONE};
    end else if (adv) begin
      ctl_q[0].valid <= in_valid && (in_req == REQ_COLOR || in_req == REQ_INTEN);
      ctl_q[0].req   <= in_req;
      for (int s = 1; s < NStg; s++) ctl_q[s] <= ctl_q[s-1];
    end
  end

  // stage 1: coordinate multiply
  texs_addr u_addr (
    .clk_i(clk_i), .en_i(adv), .cfg_i(cfg_q), .u_i(u_coord_i), .v_i(v_coord_i),
    .x0_o(x0), .x1_o(x1), .y0_o(y0), .y1_o(y1), .fa_o(fa), .fb_o(fb), .chk_o(chk)
  );

  // row-major corner addresses
  always_comb begin
    row0  = y0 * cfg_q.width;
    row1  = y1 * cfg_q.width;
    if (cfg_q.width == '0) begin
      row0 = {13'd0, y0};
      row1 = {13'd0, y1};
    end
    ra[0] = row0 + 26'(x0);
    ra[1] = row0 + 26'(x1);
    ra[2] = row1 + 26'(x0);
    ra[3] = row1 + 26'(x1);
    if (ctl_q[0].req == REQ_INTEN) begin
      ra[1] = ra[0]; ra[2] = ra[0]; ra[3] = ra[0];
    end
  end

  // stage 2 is folded into the memory read register; fixed colors travel along
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fix_q[0] <= (cfg_q.mode == MODE_SOLID) ? cfg_q.solid :
                  (cfg_q.mode == MODE_CHECK) ? chk : '0;
      fix_q[1] <= fix_q[0];
      fix_q[2] <= fix_q[1];
      fa_q     <= fa;
      fb_q     <= fb;
    end
  end

  texs_mem #(.Depth(MAX_TEXELS)) u_mem (
    .clk_i(clk_i), .en_i(adv),
    .we_i(adv && in_valid && in_req == REQ_WRITE),
    .waddr_i(texel_addr_i), .wdata_i({texel_red_i, texel_green_i, texel_blue_i}),
    .raddr_i(ra), .rdata_o(rd), .rok_o(rok)
  );

  // out of range reads give zero, gray replicates red
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rdg[k] = rok[k] ? rd[k] : '0;
      if (cfg_q.gray) rdg[k] = {3{rdg[k][2*CompW +: CompW]}};
    end
  end

  // clamped nearest-texel intensity
  always_comb begin
    isum = '0;
    for (int k = 0; k < 3; k++)
      isum = isum + 18'((rdg[0][k*CompW +: CompW] > One) ? One : rdg[0][k*CompW +: CompW]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q[0] <= isum;
      sum_q[1] <= sum_q[0];
    end
  end

  texs_blend u_blend (
    .clk_i(clk_i), .en1_i(adv), .en2_i(adv),
    .c_i(rdg), .fa_i(fa_q), .fb_i(fb_q), .c_o(bl)
  );

  // result select; the user must keep mode stable while any request is in flight, the block does not enforce it
  always_comb begin
    res = (cfg_q.mode == MODE_IMAGE) ? bl : fix_q[2];
    if (cfg_q.mode == MODE_NONE) res = '0;
  end

  assign out_valid     = ctl_q[NStg-1].valid;
  assign color_red_o   = (ctl_q[NStg-1].req == REQ_COLOR) ? res[2*CompW +: CompW] : '0;
  assign color_green_o = (ctl_q[NStg-1].req == REQ_COLOR) ? res[CompW +: CompW] : '0;
  assign color_blue_o  = (ctl_q[NStg-1].req == REQ_COLOR) ? res[0 +: CompW] : '0;
  assign intensity_o   = (ctl_q[NStg-1].req != REQ_INTEN) ? '0 :
                         (cfg_q.mode == MODE_IMAGE) ? sum_q[1] :
                         (cfg_q.mode == MODE_NONE) ? 18'd0 :
                         18'(res[2*CompW +: CompW]) + 18'(res[CompW +: CompW])
                         + 18'(res[0 +: CompW]);

  `ASSERT_PROP(a_stall_only_full, clk_i, rst_ni, in_stall |-> out_valid, "stall without result")
  `ASSERT_PROP(a_hold, clk_i, rst_ni, (out_valid && out_stall) |=> out_valid, "result dropped")
  `ASSERT_PROP(a_req_kind, clk_i, rst_ni,
               out_valid |-> (ctl_q[NStg-1].req == REQ_COLOR || ctl_q[NStg-1].req == REQ_INTEN),
               "bad request kind")
  `ASSERT_KNOWN(a_known, clk_i, rst_ni, out_valid, "unknown valid")
endmodule
